// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the averager modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define VNA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vna assertion failed");
// Antecedent implies consequent in the next cycle.
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vna assertion failed");
`endif

// ----- hdl/vna_pkg.sv -----
// Types and constants of the vertex normal averager.
package vna_pkg;

	localparam int IDX_W  = 6;
	localparam int POS_W  = 16;
	localparam int EDGE_W = 17;
	localparam int CNT_W  = 7;
	localparam int SUM_W  = 24;
	localparam int NRM_W  = 16;
	localparam int MAG_W  = 36;
	localparam int NMAG_W = 30;
	localparam int OPR_W  = 31;
	localparam int PRD_W  = 62;
	localparam int SQ_W   = 62;
	localparam int RT_W   = 64;
	localparam int LEN_W  = 31;
	localparam int NUM_W  = 45;
	localparam int REM_W  = 32;
	localparam int QUO_W  = 16;
	localparam int UNIT   = 16384;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_TRI  = 2'd1;
	localparam logic [1:0] MODE_FIN  = 2'd2;

	// Multiplier step codes: six cross product terms, then three squares.
	localparam logic [3:0] MUL_CR0_P = 4'd0;
	localparam logic [3:0] MUL_CR0_N = 4'd1;
	localparam logic [3:0] MUL_CR1_P = 4'd2;
	localparam logic [3:0] MUL_CR1_N = 4'd3;
	localparam logic [3:0] MUL_CR2_P = 4'd4;
	localparam logic [3:0] MUL_CR2_N = 4'd5;
	localparam logic [3:0] MUL_SQ_X  = 4'd6;
	localparam logic [3:0] MUL_SQ_Y  = 4'd7;
	localparam logic [3:0] MUL_SQ_Z  = 4'd8;

	localparam logic [4:0] SQRT_STEPS = 5'd31;
	localparam logic [4:0] DIV_STEPS  = 5'd15;
	localparam logic [4:0] CROSS_LAST = 5'd5;
	localparam logic [4:0] SQ_LAST    = 5'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_CAPC, ST_EDGE, ST_CROSS, ST_CROSS_W,
		ST_LDV, ST_MAX, ST_NORM, ST_SQ, ST_SQ_W, ST_SQRT_I, ST_SQRT,
		ST_DIV_I, ST_DIV_S, ST_DIV_ST, ST_ACC_RD, ST_ACC_WR, ST_FIN_RD, ST_OUT
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             pos_we;
		logic [1:0]       pos_rd_sel;
		logic             pos_rd;
		logic             cap_a;
		logic             cap_b;
		logic             cap_c;
		logic             edge_en;
		logic             mul_go;
		logic [3:0]       mul_sel;
		logic             load_vec;
		logic             load_sum;
		logic             max_en;
		logic             norm_step;
		logic             sqrt_init;
		logic             sqrt_step;
		logic             div_init;
		logic             div_step;
		logic             div_store;
		logic [1:0]       comp;
		logic             sum_rd;
		logic             sum_we;
		logic             sum_clear;
		logic             use_vertex;
		logic [IDX_W-1:0] vertex;
		logic             out_load;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       load_ok;
		logic       tri_ok;
		logic       zero;
		logic       norm_done;
		logic       out_free;
	} sts_t;

endpackage

// ----- hdl/vna_if.sv -----
// Request and result channel interfaces of the vertex normal averager.
interface vna_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [5:0]  vertex_index;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [5:0]  corner_a;
	logic [5:0]  corner_b;
	logic [5:0]  corner_c;
	modport source (output valid, mode, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, mode, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_vertex;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic        degenerate;
	logic        last;
	modport source (output valid, out_vertex, normal_x, normal_y, normal_z,
		degenerate, last, input ready);
	modport sink (input valid, out_vertex, normal_x, normal_y, normal_z,
		degenerate, last, output ready);
endinterface

// ----- hdl/vna_dp.sv -----
// Datapath: position and sum memories, shared multiplier, square root and divider.
`include "assert_macros.svh"
module vna_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	vna_in_if.sink        req,
	vna_out_if.source     rsp,
	input  vna_pkg::cmd_t cmd,
	output vna_pkg::sts_t sts
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	// Memories.
	logic [3*vna_pkg::POS_W-1:0] pos_mem [MAX_VERTICES];
	logic [3*vna_pkg::SUM_W-1:0] sum_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]     sum_vld_q;

	logic [vna_pkg::IDX_W-1:0]   corner_q [3];
	logic [3*vna_pkg::POS_W-1:0] pos_rd_q;
	logic [3*vna_pkg::POS_W-1:0] pa_q, pb_q, pc_q;
	logic signed [vna_pkg::EDGE_W-1:0] e1_q [3];
	logic signed [vna_pkg::EDGE_W-1:0] e2_q [3];

	logic signed [vna_pkg::OPR_W-1:0] op_a, op_b;
	logic signed [vna_pkg::PRD_W-1:0] prod_s1;
	logic [3:0]                       sel_s1;
	logic                             vld_s1;
	logic signed [vna_pkg::MAG_W-1:0] cross_q [3];
	logic [vna_pkg::SQ_W-1:0]         sq_q;

	logic [vna_pkg::MAG_W-1:0] mag_q [3];
	logic                      neg_q [3];
	logic [vna_pkg::MAG_W-1:0] m_q;
	logic signed [vna_pkg::MAG_W-1:0] vec [3];

	logic [vna_pkg::SQ_W-1:0] x_q;
	logic [vna_pkg::RT_W-1:0] res_q, bit_q, rt_try;
	logic [vna_pkg::LEN_W-1:0] len;

	logic [vna_pkg::NUM_W-1:0] num;
	logic [vna_pkg::REM_W-1:0] r_q, r_sh;
	logic [vna_pkg::QUO_W-1:0] numlo_q, q_q, q_clamp;
	logic signed [vna_pkg::NRM_W-1:0] n_q [3];

	logic [vna_pkg::IDX_W-1:0] sum_addr;
	logic [3*vna_pkg::SUM_W-1:0] sum_rd_q;
	logic                        sum_rd_vld_s1;
	logic signed [vna_pkg::SUM_W-1:0] sum_cur [3];
	logic signed [vna_pkg::SUM_W:0]   sum_new [3];
	logic signed [vna_pkg::SUM_W-1:0] sum_sat [3];

	logic out_valid_q;
	logic out_free;

	// Status toward the controller.
	assign out_free = !out_valid_q || rsp.ready;
	always_comb begin
		sts.mode      = req.mode;
		sts.load_ok   = {1'b0, req.vertex_index} < vna_pkg::CNT_W'(MAX_VERTICES);
		sts.tri_ok    = ({1'b0, req.corner_a} < vna_pkg::CNT_W'(MAX_VERTICES)) &&
			({1'b0, req.corner_b} < vna_pkg::CNT_W'(MAX_VERTICES)) &&
			({1'b0, req.corner_c} < vna_pkg::CNT_W'(MAX_VERTICES));
		sts.zero      = (m_q == '0);
		sts.norm_done = (m_q[vna_pkg::MAG_W-1:vna_pkg::NMAG_W] == '0) &&
			m_q[vna_pkg::NMAG_W-1];
		sts.out_free  = out_free;
	end

	// Position memory: written on a load request, read one corner a cycle.
	always_ff @(posedge clk) begin
		if (cmd.pos_we) begin
			pos_mem[req.vertex_index[AW-1:0]] <= {req.pos_x, req.pos_y, req.pos_z};
		end
		if (cmd.pos_rd) begin
			pos_rd_q <= pos_mem[corner_q[cmd.pos_rd_sel][AW-1:0]];
		end
	end

	// Corner capture and edge vectors.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			corner_q[0] <= req.corner_a;
			corner_q[1] <= req.corner_b;
			corner_q[2] <= req.corner_c;
		end
		if (cmd.cap_a) pa_q <= pos_rd_q;
		if (cmd.cap_b) pb_q <= pos_rd_q;
		if (cmd.cap_c) pc_q <= pos_rd_q;
		if (cmd.edge_en) begin
			for (int j = 0; j < 3; j++) begin
				e1_q[j] <= $signed({pb_q[(2-j)*vna_pkg::POS_W+vna_pkg::POS_W-1],
					pb_q[(2-j)*vna_pkg::POS_W +: vna_pkg::POS_W]}) -
					$signed({pa_q[(2-j)*vna_pkg::POS_W+vna_pkg::POS_W-1],
					pa_q[(2-j)*vna_pkg::POS_W +: vna_pkg::POS_W]});
				e2_q[j] <= $signed({pc_q[(2-j)*vna_pkg::POS_W+vna_pkg::POS_W-1],
					pc_q[(2-j)*vna_pkg::POS_W +: vna_pkg::POS_W]}) -
					$signed({pa_q[(2-j)*vna_pkg::POS_W+vna_pkg::POS_W-1],
					pa_q[(2-j)*vna_pkg::POS_W +: vna_pkg::POS_W]});
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			vna_pkg::MUL_CR0_P: begin op_a = OPR_EXT(e1_q[1]); op_b = OPR_EXT(e2_q[2]); end
			vna_pkg::MUL_CR0_N: begin op_a = OPR_EXT(e1_q[2]); op_b = OPR_EXT(e2_q[1]); end
			vna_pkg::MUL_CR1_P: begin op_a = OPR_EXT(e1_q[2]); op_b = OPR_EXT(e2_q[0]); end
			vna_pkg::MUL_CR1_N: begin op_a = OPR_EXT(e1_q[0]); op_b = OPR_EXT(e2_q[2]); end
			vna_pkg::MUL_CR2_P: begin op_a = OPR_EXT(e1_q[0]); op_b = OPR_EXT(e2_q[1]); end
			vna_pkg::MUL_CR2_N: begin op_a = OPR_EXT(e1_q[1]); op_b = OPR_EXT(e2_q[0]); end
			vna_pkg::MUL_SQ_X: begin
				op_a = $signed({1'b0, mag_q[0][vna_pkg::NMAG_W-1:0]});
				op_b = op_a;
			end
			vna_pkg::MUL_SQ_Y: begin
				op_a = $signed({1'b0, mag_q[1][vna_pkg::NMAG_W-1:0]});
				op_b = op_a;
			end
			vna_pkg::MUL_SQ_Z: begin
				op_a = $signed({1'b0, mag_q[2][vna_pkg::NMAG_W-1:0]});
				op_b = op_a;
			end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	function automatic logic signed [vna_pkg::OPR_W-1:0] OPR_EXT(
		input logic signed [vna_pkg::EDGE_W-1:0] v);
		OPR_EXT = vna_pkg::OPR_W'(v);
	endfunction

	// Product register, then accumulation into the cross or square sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sel_s1  <= cmd.mul_sel;
		if (cmd.edge_en) begin
			for (int j = 0; j < 3; j++) cross_q[j] <= '0;
		end else if (vld_s1) begin
			case (sel_s1)
				vna_pkg::MUL_CR0_P: cross_q[0] <= cross_q[0] + prod_s1[vna_pkg::MAG_W-1:0];
				vna_pkg::MUL_CR0_N: cross_q[0] <= cross_q[0] - prod_s1[vna_pkg::MAG_W-1:0];
				vna_pkg::MUL_CR1_P: cross_q[1] <= cross_q[1] + prod_s1[vna_pkg::MAG_W-1:0];
				vna_pkg::MUL_CR1_N: cross_q[1] <= cross_q[1] - prod_s1[vna_pkg::MAG_W-1:0];
				vna_pkg::MUL_CR2_P: cross_q[2] <= cross_q[2] + prod_s1[vna_pkg::MAG_W-1:0];
				vna_pkg::MUL_CR2_N: cross_q[2] <= cross_q[2] - prod_s1[vna_pkg::MAG_W-1:0];
				default: ;
			endcase
		end
		if (cmd.load_vec) begin
			sq_q <= '0;
		end else if (vld_s1 && (sel_s1 == vna_pkg::MUL_SQ_X || sel_s1 == vna_pkg::MUL_SQ_Y ||
			sel_s1 == vna_pkg::MUL_SQ_Z)) begin
			sq_q <= sq_q + prod_s1[vna_pkg::SQ_W-1:0];
		end
	end

	// Vector to normalize: the cross product or a stored sum.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_cur[j] = sum_rd_vld_s1 ?
				$signed(sum_rd_q[(2-j)*vna_pkg::SUM_W +: vna_pkg::SUM_W]) : '0;
			vec[j] = cmd.load_sum ? vna_pkg::MAG_W'(sum_cur[j]) : cross_q[j];
		end
	end

	// Magnitudes, maximum and normalizing shift, one bit a cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_vec) begin
			for (int j = 0; j < 3; j++) begin
				neg_q[j] <= vec[j][vna_pkg::MAG_W-1];
				mag_q[j] <= vec[j][vna_pkg::MAG_W-1] ? vna_pkg::MAG_W'(-vec[j]) :
					vna_pkg::MAG_W'(vec[j]);
			end
		end else if (cmd.norm_step) begin
			for (int j = 0; j < 3; j++) begin
				mag_q[j] <= (m_q[vna_pkg::MAG_W-1:vna_pkg::NMAG_W] != '0) ?
					(mag_q[j] >> 1) : (mag_q[j] << 1);
			end
		end
		if (cmd.max_en) begin
			m_q <= (mag_q[0] > mag_q[1]) ?
				((mag_q[0] > mag_q[2]) ? mag_q[0] : mag_q[2]) :
				((mag_q[1] > mag_q[2]) ? mag_q[1] : mag_q[2]);
		end else if (cmd.norm_step) begin
			m_q <= (m_q[vna_pkg::MAG_W-1:vna_pkg::NMAG_W] != '0) ? (m_q >> 1) : (m_q << 1);
		end
	end

	// Bit-pair square root of the sum of squares.
	assign rt_try = res_q + bit_q;
	assign len    = res_q[vna_pkg::LEN_W-1:0];
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			x_q   <= sq_q;
			res_q <= '0;
			bit_q <= vna_pkg::RT_W'(1) << (vna_pkg::SQ_W);
		end else if (cmd.sqrt_step) begin
			if ({2'b00, x_q} >= rt_try) begin
				x_q   <= x_q - rt_try[vna_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Restoring divider: one quotient bit a cycle, rounded by adding len / 2.
	assign num  = {1'b0, mag_q[cmd.comp][vna_pkg::NMAG_W-1:0], 14'd0} +
		vna_pkg::NUM_W'(len >> 1);
	assign r_sh = {r_q[vna_pkg::REM_W-2:0], numlo_q[vna_pkg::QUO_W-1]};
	assign q_clamp = (q_q > vna_pkg::QUO_W'(vna_pkg::UNIT)) ?
		vna_pkg::QUO_W'(vna_pkg::UNIT) : q_q;
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			r_q     <= vna_pkg::REM_W'(num[vna_pkg::NUM_W-1:vna_pkg::QUO_W]);
			numlo_q <= num[vna_pkg::QUO_W-1:0];
			q_q     <= '0;
		end else if (cmd.div_step) begin
			if (r_sh >= {1'b0, len}) begin
				r_q <= r_sh - {1'b0, len};
				q_q <= {q_q[vna_pkg::QUO_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[vna_pkg::QUO_W-2:0], 1'b0};
			end
			numlo_q <= numlo_q << 1;
		end
		if (cmd.load_vec) begin
			for (int j = 0; j < 3; j++) n_q[j] <= '0;
		end else if (cmd.div_store) begin
			n_q[cmd.comp] <= neg_q[cmd.comp] ? -$signed(q_clamp) : $signed(q_clamp);
		end
	end

	// Sum memory: read-modify-write of one corner, valid bits for the cleared state.
	assign sum_addr = cmd.use_vertex ? cmd.vertex : corner_q[cmd.comp];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_new[j] = (vna_pkg::SUM_W+1)'(sum_cur[j]) + (vna_pkg::SUM_W+1)'(n_q[j]);
			if (sum_new[j] > $signed((vna_pkg::SUM_W+1)'(2**(vna_pkg::SUM_W-1) - 1))) begin
				sum_sat[j] = {1'b0, {(vna_pkg::SUM_W-1){1'b1}}};
			end else if (sum_new[j] < -$signed((vna_pkg::SUM_W+1)'(2**(vna_pkg::SUM_W-1)))) begin
				sum_sat[j] = {1'b1, {(vna_pkg::SUM_W-1){1'b0}}};
			end else begin
				sum_sat[j] = sum_new[j][vna_pkg::SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_rd) begin
			sum_rd_q <= sum_mem[sum_addr[AW-1:0]];
		end
		if (cmd.sum_we) begin
			sum_mem[sum_addr[AW-1:0]] <= {sum_sat[0], sum_sat[1], sum_sat[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q     <= '0;
			sum_rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.sum_rd) sum_rd_vld_s1 <= sum_vld_q[sum_addr[AW-1:0]];
			if (cmd.sum_clear) begin
				sum_vld_q <= '0;
			end else if (cmd.sum_we) begin
				sum_vld_q[sum_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.out_vertex <= cmd.vertex;
			rsp.normal_x   <= n_q[0];
			rsp.normal_y   <= n_q[1];
			rsp.normal_z   <= n_q[2];
			rsp.degenerate <= sts.zero;
			rsp.last       <= cmd.out_last;
		end
	end

	assign rsp.valid = out_valid_q;

	`VNA_ASSERT_SAME(a_out_no_overwrite, clk, arst_n, cmd.out_load, out_free)
	`VNA_ASSERT_SAME(a_div_normalized, clk, arst_n, cmd.div_init,
		(m_q[vna_pkg::MAG_W-1:vna_pkg::NMAG_W] == '0) && m_q[vna_pkg::NMAG_W-1])
	`VNA_ASSERT_SAME(a_quot_bound, clk, arst_n, cmd.div_store,
		q_q <= vna_pkg::QUO_W'(vna_pkg::UNIT + 1))
endmodule

// ----- hdl/vna_ctrl.sv -----
// Controller: sequences loads, triangle accumulation and the finish run.
`include "assert_macros.svh"
module vna_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cfg_we,
	input  logic [vna_pkg::CNT_W-1:0] cfg_wdata,
	input  vna_pkg::sts_t             sts,
	output vna_pkg::cmd_t             cmd
);
	vna_pkg::state_t st_q, st_d;
	logic [4:0] step_q, step_d;
	logic [1:0] comp_q, comp_d;
	logic       fin_q, fin_d;
	logic [vna_pkg::IDX_W-1:0] vidx_q, vidx_d;
	logic [vna_pkg::CNT_W-1:0] vcount_q, cnt;
	logic       is_last;

	// Vertex count register, saturated to the store depth when used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= vna_pkg::CNT_W'(64);
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end
	assign cnt = (vcount_q > vna_pkg::CNT_W'(MAX_VERTICES)) ?
		vna_pkg::CNT_W'(MAX_VERTICES) : vcount_q;
	assign is_last = ({1'b0, vidx_q} + vna_pkg::CNT_W'(1)) == cnt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= vna_pkg::ST_IDLE;
			step_q <= '0;
			comp_q <= '0;
			fin_q  <= 1'b0;
			vidx_q <= '0;
		end else begin
			st_q   <= st_d;
			step_q <= step_d;
			comp_q <= comp_d;
			fin_q  <= fin_d;
			vidx_q <= vidx_d;
		end
	end

	// Next state and commands.
	always_comb begin
		st_d     = st_q;
		step_d   = step_q;
		comp_d   = comp_q;
		fin_d    = fin_q;
		vidx_d   = vidx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.comp   = comp_q;
		cmd.vertex = vidx_q;
		cmd.mul_sel = vna_pkg::MUL_CR0_P;
		case (st_q)
			vna_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					case (sts.mode)
						vna_pkg::MODE_LOAD: cmd.pos_we = sts.load_ok;
						vna_pkg::MODE_TRI: begin
							if (sts.tri_ok) begin
								fin_d = 1'b0;
								st_d  = vna_pkg::ST_RDA;
							end
						end
						vna_pkg::MODE_FIN: begin
							if (cnt == '0) begin
								cmd.sum_clear = 1'b1;
							end else begin
								fin_d  = 1'b1;
								vidx_d = '0;
								st_d   = vna_pkg::ST_FIN_RD;
							end
						end
						default: ;
					endcase
				end
			end
			vna_pkg::ST_RDA: begin
				cmd.pos_rd = 1'b1;
				cmd.pos_rd_sel = 2'd0;
				st_d = vna_pkg::ST_RDB;
			end
			vna_pkg::ST_RDB: begin
				cmd.pos_rd = 1'b1;
				cmd.pos_rd_sel = 2'd1;
				cmd.cap_a = 1'b1;
				st_d = vna_pkg::ST_RDC;
			end
			vna_pkg::ST_RDC: begin
				cmd.pos_rd = 1'b1;
				cmd.pos_rd_sel = 2'd2;
				cmd.cap_b = 1'b1;
				st_d = vna_pkg::ST_CAPC;
			end
			vna_pkg::ST_CAPC: begin
				cmd.cap_c = 1'b1;
				st_d = vna_pkg::ST_EDGE;
			end
			vna_pkg::ST_EDGE: begin
				cmd.edge_en = 1'b1;
				step_d = '0;
				st_d = vna_pkg::ST_CROSS;
			end
			// Six products, each added to or subtracted from its component.
			vna_pkg::ST_CROSS: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = step_q[3:0];
				step_d = step_q + 5'd1;
				if (step_q == vna_pkg::CROSS_LAST) st_d = vna_pkg::ST_CROSS_W;
			end
			vna_pkg::ST_CROSS_W: st_d = vna_pkg::ST_LDV;
			vna_pkg::ST_LDV: begin
				cmd.load_vec = 1'b1;
				cmd.load_sum = fin_q;
				st_d = vna_pkg::ST_MAX;
			end
			vna_pkg::ST_MAX: begin
				cmd.max_en = 1'b1;
				st_d = vna_pkg::ST_NORM;
			end
			vna_pkg::ST_NORM: begin
				step_d = '0;
				if (sts.zero) begin
					st_d = fin_q ? vna_pkg::ST_OUT : vna_pkg::ST_IDLE;
				end else if (sts.norm_done) begin
					st_d = vna_pkg::ST_SQ;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			vna_pkg::ST_SQ: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = vna_pkg::MUL_SQ_X + step_q[3:0];
				step_d = step_q + 5'd1;
				if (step_q == vna_pkg::SQ_LAST) st_d = vna_pkg::ST_SQ_W;
			end
			vna_pkg::ST_SQ_W: st_d = vna_pkg::ST_SQRT_I;
			vna_pkg::ST_SQRT_I: begin
				cmd.sqrt_init = 1'b1;
				step_d = '0;
				st_d = vna_pkg::ST_SQRT;
			end
			vna_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == vna_pkg::SQRT_STEPS) begin
					comp_d = '0;
					st_d = vna_pkg::ST_DIV_I;
				end
			end
			vna_pkg::ST_DIV_I: begin
				cmd.div_init = 1'b1;
				step_d = '0;
				st_d = vna_pkg::ST_DIV_S;
			end
			vna_pkg::ST_DIV_S: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 5'd1;
				if (step_q == vna_pkg::DIV_STEPS) st_d = vna_pkg::ST_DIV_ST;
			end
			vna_pkg::ST_DIV_ST: begin
				cmd.div_store = 1'b1;
				if (comp_q == 2'd2) begin
					comp_d = '0;
					st_d = fin_q ? vna_pkg::ST_OUT : vna_pkg::ST_ACC_RD;
				end else begin
					comp_d = comp_q + 2'd1;
					st_d = vna_pkg::ST_DIV_I;
				end
			end
			// Corner sums are updated one after another so a repeated corner adds twice.
			vna_pkg::ST_ACC_RD: begin
				cmd.sum_rd = 1'b1;
				st_d = vna_pkg::ST_ACC_WR;
			end
			vna_pkg::ST_ACC_WR: begin
				cmd.sum_we = 1'b1;
				if (comp_q == 2'd2) begin
					comp_d = '0;
					st_d = vna_pkg::ST_IDLE;
				end else begin
					comp_d = comp_q + 2'd1;
					st_d = vna_pkg::ST_ACC_RD;
				end
			end
			vna_pkg::ST_FIN_RD: begin
				cmd.sum_rd = 1'b1;
				cmd.use_vertex = 1'b1;
				st_d = vna_pkg::ST_LDV;
			end
			vna_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = is_last;
					if (is_last) begin
						cmd.sum_clear = 1'b1;
						st_d = vna_pkg::ST_IDLE;
					end else begin
						vidx_d = vidx_q + 6'd1;
						st_d = vna_pkg::ST_FIN_RD;
					end
				end
			end
			default: st_d = vna_pkg::ST_IDLE;
		endcase
	end

	`VNA_ASSERT_SAME(a_last_clears, clk, arst_n, cmd.out_load && cmd.out_last, cmd.sum_clear)
	`VNA_ASSERT_SAME(a_we_not_clear, clk, arst_n, cmd.sum_we, !cmd.sum_clear)
	`VNA_ASSERT_NEXT(a_tri_starts, clk, arst_n,
		cmd.accept && sts.mode == vna_pkg::MODE_TRI && sts.tri_ok, st_q == vna_pkg::ST_RDA)
endmodule

// ----- hdl/vertex_normal_averager.sv -----
// Top level of the vertex normal averager.
// Channels: req takes requests (load a vertex position, add a triangle, or
// finish); rsp carries one unit normal per vertex in use during a finish run,
// the final one marked by last. A valid/ready pair moves each request.
// cfg_we with cfg_wdata writes vertex_count; the user must write it only while the
// block is idle, and the block itself does not enforce this. A triangle goes through
// the position reads, the cross product on the shared multiplier and, unless the
// cross product is zero, the one-bit-a-cycle normalizing shift, the squares, the
// square root, the three 16-step divisions and the read-modify-write of the three
// corner sums. A finish spends the same normalize, square root and divide sequence
// on every vertex whose sum is nonzero. Requests are taken one at a time;
// req.ready is high only while no request is in progress.
// Reset clears all sums and sets vertex_count to 64; positions are unknown
// until loaded. When rsp stalls, the finish run waits with the next normal
// finished until the result register is free; nothing is dropped.
module vertex_normal_averager #(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	vna_in_if.sink      req,
	vna_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	vna_pkg::cmd_t cmd;
	vna_pkg::sts_t sts;

	// Sequencer.
	vna_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and storage.
	vna_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ----- tb/tb_vertex_normal_averager.sv -----
// Self-checking testbench of the vertex normal averager.
module tb_vertex_normal_averager;
	import vna_pkg::*;

	// Mode code that the block must ignore.
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int VERTS = 64;
	localparam int SUM_HI = 8388607;
	localparam int SUM_LO = -8388608;
	localparam int LIMIT = 3000000;
	localparam int SETTLE = 300;

	typedef struct {
		logic [1:0]         mode;
		logic [5:0]         idx;
		logic signed [15:0] x, y, z;
		logic [5:0]         a, b, c;
		bit                 typed;
		logic signed [15:0] tx, ty, tz;
		bit                 tdeg;
	} request_t;

	typedef struct {
		logic [5:0]         vtx;
		logic signed [15:0] nx, ny, nz;
		logic               deg;
		logic               last;
	} normal_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;

	vna_in_if req_if();
	vna_out_if rsp_if();

	vertex_normal_averager dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow state of the block.
	logic signed [15:0] pos_x_sh[VERTS], pos_y_sh[VERTS], pos_z_sh[VERTS];
	int sum_x_sh[VERTS], sum_y_sh[VERTS], sum_z_sh[VERTS];
	int unsigned count_sh;
	normal_t normal_q[$];
	request_t drv_req;
	int fail_cnt;
	int cycle_cnt;
	bit calm;
	bit hold_req;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Floor square root of a 64-bit value.
	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Scale a vector to unit length in Q1.14; returns 0 for a zero vector.
	function automatic bit to_unit(input longint vx, input longint vy, input longint vz,
			output int nx, output int ny, output int nz);
		longint v[3];
		longint unsigned mag[3], m, sq, len, q;
		int n[3];
		v[0] = vx; v[1] = vy; v[2] = vz;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (mag[i] > m) m = mag[i];
			n[i] = 0;
		end
		nx = 0; ny = 0; nz = 0;
		if (m == 0) return 1'b0;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len = root64(sq);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * UNIT + len / 2) / len;
			if (q > UNIT) q = UNIT;
			n[i] = v[i] < 0 ? -int'(q) : int'(q);
		end
		nx = n[0]; ny = n[1]; nz = n[2];
		return 1'b1;
	endfunction

	function automatic int sat_sum(input int s, input int d);
		int r;
		r = s + d;
		if (r > SUM_HI) r = SUM_HI;
		if (r < SUM_LO) r = SUM_LO;
		return r;
	endfunction

	// Update the shadow state for one accepted request and queue its normals.
	task automatic predict(input request_t r);
		longint e1[3], e2[3], cx, cy, cz;
		int nx, ny, nz, cnt;
		int corner[3];
		bit ok;
		normal_t e;
		case (r.mode)
			MODE_LOAD: begin
				pos_x_sh[r.idx] = r.x;
				pos_y_sh[r.idx] = r.y;
				pos_z_sh[r.idx] = r.z;
			end
			MODE_TRI: begin
				corner[0] = r.a; corner[1] = r.b; corner[2] = r.c;
				e1[0] = longint'(pos_x_sh[r.b]) - pos_x_sh[r.a];
				e1[1] = longint'(pos_y_sh[r.b]) - pos_y_sh[r.a];
				e1[2] = longint'(pos_z_sh[r.b]) - pos_z_sh[r.a];
				e2[0] = longint'(pos_x_sh[r.c]) - pos_x_sh[r.a];
				e2[1] = longint'(pos_y_sh[r.c]) - pos_y_sh[r.a];
				e2[2] = longint'(pos_z_sh[r.c]) - pos_z_sh[r.a];
				cx = e1[1] * e2[2] - e1[2] * e2[1];
				cy = e1[2] * e2[0] - e1[0] * e2[2];
				cz = e1[0] * e2[1] - e1[1] * e2[0];
				if (to_unit(cx, cy, cz, nx, ny, nz)) begin
					for (int k = 0; k < 3; k++) begin
						sum_x_sh[corner[k]] = sat_sum(sum_x_sh[corner[k]], nx);
						sum_y_sh[corner[k]] = sat_sum(sum_y_sh[corner[k]], ny);
						sum_z_sh[corner[k]] = sat_sum(sum_z_sh[corner[k]], nz);
					end
				end
			end
			MODE_FIN: begin
				cnt = count_sh > VERTS ? VERTS : count_sh;
				for (int i = 0; i < cnt; i++) begin
					ok = to_unit(sum_x_sh[i], sum_y_sh[i], sum_z_sh[i], nx, ny, nz);
					e.vtx = i;
					e.nx = nx; e.ny = ny; e.nz = nz;
					e.deg = !ok;
					e.last = (i + 1 == cnt);
					if (r.typed) begin
						e.nx = r.tx; e.ny = r.ty; e.nz = r.tz; e.deg = r.tdeg;
					end
					normal_q.push_back(e);
				end
				for (int i = 0; i < VERTS; i++) begin
					sum_x_sh[i] = 0; sum_y_sh[i] = 0; sum_z_sh[i] = 0;
				end
			end
			default: ;
		endcase
	endtask

	// Watch both channels; predict on each accepted request, check each normal.
	always @(posedge clk) begin
		normal_t e;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) predict(drv_req);
			if (rsp_if.valid && rsp_if.ready) begin
				if (normal_q.size() == 0) begin
					$display("%0t: unexpected normal for vertex %0d", $time,
						rsp_if.out_vertex);
					fail_cnt++;
				end else begin
					e = normal_q.pop_front();
					if (rsp_if.out_vertex !== e.vtx || rsp_if.normal_x !== e.nx ||
							rsp_if.normal_y !== e.ny || rsp_if.normal_z !== e.nz ||
							rsp_if.degenerate !== e.deg || rsp_if.last !== e.last) begin
						$display("%0t: expected v%0d (%0d,%0d,%0d) deg %b last %b, got v%0d (%0d,%0d,%0d) deg %b last %b",
							$time, e.vtx, e.nx, e.ny, e.nz, e.deg, e.last,
							rsp_if.out_vertex, rsp_if.normal_x, rsp_if.normal_y,
							rsp_if.normal_z, rsp_if.degenerate, rsp_if.last);
						fail_cnt++;
					end
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offer one request and hold it until it is taken, then maybe go idle.
	task automatic send_req(input request_t r);
		req_if.valid <= 1'b1;
		req_if.mode <= r.mode;
		req_if.vertex_index <= r.idx;
		req_if.pos_x <= r.x;
		req_if.pos_y <= r.y;
		req_if.pos_z <= r.z;
		req_if.corner_a <= r.a;
		req_if.corner_b <= r.b;
		req_if.corner_c <= r.c;
		drv_req <= r;
		do @(posedge clk); while (!req_if.ready);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Wait for every pending normal, then let a triangle in flight finish.
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (normal_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_sh = v;
		@(posedge clk);
	endtask

	function automatic request_t make_req(input logic [1:0] mode, input int idx,
			input int x, input int y, input int z, input int a, input int b, input int c);
		request_t r;
		r.mode = mode; r.idx = idx; r.x = x; r.y = y; r.z = z;
		r.a = a; r.b = b; r.c = c;
		r.typed = 1'b0; r.tx = 0; r.ty = 0; r.tz = 0; r.tdeg = 1'b0;
		return r;
	endfunction

	function automatic request_t rand_req();
		request_t r;
		int p;
		r = make_req(2'd0, $urandom_range(0, 63), $urandom, $urandom, $urandom,
			$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
		p = $urandom_range(0, 99);
		if (p < 25) r.mode = MODE_LOAD;
		else if (p < 90) r.mode = MODE_TRI;
		else if (p < 95) r.mode = MODE_FIN;
		else r.mode = MODE_NOP;
		// Small coordinates now and then, so that sums build up in nearby ranges.
		if (r.mode == MODE_LOAD && $urandom_range(0, 1) == 0) begin
			r.x = $signed(16'($urandom_range(0, 1023))) - 512;
			r.y = $signed(16'($urandom_range(0, 1023))) - 512;
			r.z = $signed(16'($urandom_range(0, 1023))) - 512;
		end
		return r;
	endfunction

	request_t plan[$];
	request_t r;
	logic [6:0] counts[6];

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.mode = MODE_LOAD;
		req_if.vertex_index = '0;
		req_if.pos_x = '0;
		req_if.pos_y = '0;
		req_if.pos_z = '0;
		req_if.corner_a = '0;
		req_if.corner_b = '0;
		req_if.corner_c = '0;
		fail_cnt = 0;
		cycle_cnt = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		count_sh = 64;
		for (int i = 0; i < VERTS; i++) begin
			pos_x_sh[i] = 0; pos_y_sh[i] = 0; pos_z_sh[i] = 0;
			sum_x_sh[i] = 0; sum_y_sh[i] = 0; sum_z_sh[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: finish right after reset gives all-zero degenerate normals.
		r = make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0);
		r.typed = 1'b1; r.tdeg = 1'b1;
		plan.push_back(r);
		plan.push_back(make_req(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(make_req(MODE_LOAD, 1, 256, 0, 0, 0, 0, 0));
		plan.push_back(make_req(MODE_LOAD, 2, 0, 256, 0, 0, 0, 0));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 0, 1, 2));
		plan.push_back(make_req(MODE_LOAD, 63, 32767, 32767, 32767, 0, 0, 0));
		plan.push_back(make_req(MODE_LOAD, 62, -32768, -32768, -32768, 0, 0, 0));
		plan.push_back(make_req(MODE_LOAD, 61, 32767, -32768, 0, 0, 0, 0));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 63, 62, 61));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 61, 63, 62));
		// Repeated corner and collinear corners give a zero cross product.
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 0, 0, 1));
		plan.push_back(make_req(MODE_LOAD, 3, 512, 0, 0, 0, 0, 0));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 0, 1, 3));
		plan.push_back(make_req(MODE_NOP, 63, -1, -1, -1, 63, 63, 63));
		plan.push_back(make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0));
		// Opposite windings cancel, so the finish reports degenerate sums.
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 0, 1, 2));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 0, 2, 1));
		plan.push_back(make_req(MODE_TRI, 0, 0, 0, 0, 63, 0, 62));
		plan.push_back(make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0));
		foreach (plan[i]) send_req(plan[i]);
		drain();

		// Load every vertex so that any triangle reads written positions.
		for (int i = 0; i < VERTS; i++) begin
			r = rand_req();
			r.mode = MODE_LOAD;
			r.idx = i;
			send_req(r);
		end

		// Random phases over several vertex counts, extremes among them.
		counts = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd5, 7'($urandom_range(1, 127))};
		foreach (counts[p]) begin
			drain();
			write_count(counts[p]);
			for (int i = 0; i < 45; i++) begin
				r = rand_req();
				if (counts[p] == 7'd64 && i == 20) begin
					r.mode = MODE_FIN;
					hold_req = 1'b1;
				end
				send_req(r);
			end
			send_req(make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0));
		end

		// Drive the sums of one triangle into saturation.
		drain();
		write_count(7'd3);
		send_req(make_req(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(MODE_LOAD, 1, 256, 0, 0, 0, 0, 0));
		send_req(make_req(MODE_LOAD, 2, 0, 0, -256, 0, 0, 0));
		for (int i = 0; i < 560; i++) send_req(make_req(MODE_TRI, 0, 0, 0, 0, 0, 1, 2));
		send_req(make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0));

		// Last stretch with no idling on either side.
		drain();
		write_count(7'd9);
		calm = 1'b1;
		for (int i = 0; i < 40; i++) send_req(rand_req());
		send_req(make_req(MODE_FIN, 0, 0, 0, 0, 0, 0, 0));
		drain();

		if (normal_q.size() != 0) begin
			$display("%0t: %0d normals never arrived", $time, normal_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/vna_pkg.sv
hdl/vna_if.sv
hdl/vna_dp.sv
hdl/vna_ctrl.sv
hdl/vertex_normal_averager.sv
tb/tb_vertex_normal_averager.sv
